// ===== sv/ldh_pkg.sv =====
// ============================================================================
// Leading digit histogram package
// Shared constants, the sequencer state type and the limb arithmetic sizes.
// ============================================================================
package ldh_pkg;

	// Width of one histogram bin and of the bin count field on the result port.
	localparam int COUNT_WIDTH  = 32;
	localparam int RESULT_CNT_W = 32;

	// Ten bins, one for each leading decimal digit, zero included.
	localparam int BIN_COUNT = 10;
	localparam int BIN_IW    = 4;

	// Result beat kinds: the digit of a sample, or one bin of a report.
	localparam logic KIND_DIGIT  = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// The exact magnitude is held as a long integer in 16-bit limbs.
	localparam int LIMB_W     = 16;
	localparam int LIMB_COUNT = 72;
	localparam int LIMB_AW    = $clog2(LIMB_COUNT);

	// Divide by ten of a value below 10 * 2^16 by a reciprocal multiply:
	// q = (x * 419431) >> 22 is exact for every x below 699050.
	localparam int             DIV10_SHIFT = 22;
	localparam logic [18:0]    DIV10_RECIP = 19'd419431;

	// binary64 field layout
	localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
	localparam logic [10:0] EXP_BIAS_INT = 11'd1075;
	localparam logic [10:0] SUBNORM_K    = 11'd1074;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LOAD,
		ST_ISSUE,
		ST_PASS,
		ST_COUNT,
		ST_REPORT
	} ldh_state_t;

endpackage

// ===== sv/ldh_if.sv =====
// ============================================================================
// Leading digit histogram channels
// Valid/ready channels for samples going in and results coming out.
// ============================================================================
interface ldh_sample_if;
	logic        valid;
	logic        ready;
	logic [63:0] sample_bits;
	logic        final_sample;

	modport source (output valid, output sample_bits, output final_sample, input ready);
	modport sink   (input valid, input sample_bits, input final_sample, output ready);
endinterface

interface ldh_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [3:0]  digit;
	logic [31:0] bin_count;
	logic        run_end;

	modport source (output valid, output kind, output digit, output bin_count,
		output run_end, input ready);
	modport sink   (input valid, input kind, input digit, input bin_count,
		input run_end, output ready);
endinterface

// ===== sv/ldh_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port, read data registered.
// ============================================================================
module ldh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 72
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/leading_digit_histogram_unit.sv =====
// ============================================================================
// Leading digit histogram unit
// Finds the exact leading decimal digit of each binary64 sample, counts it in
// one of ten saturating bins and reports and clears the bins on request.
// ============================================================================
//
//  channel   dir  payload                               beat meaning
//  --------  ---  ------------------------------------  ---------------------------
//  samples   in   sample_bits[63:0], final_sample       one sample to classify
//  results   out  kind, digit[3:0], bin_count[31:0],    digit of a sample (kind 0)
//                 run_end                               or one bin report (kind 1)
//
//  An accepted sample goes through decode, then a load of the magnitude into
//  the limb RAM limb by limb, then one pass per decade of scaling through the
//  single multiply/divide-by-ten unit: a pass is an issue step and a walk over
//  the active limbs, and a multiply pass also writes its carry limb. The count
//  state then loads the digit beat once the result register is free, and the
//  unit returns to idle for the next sample. Magnitudes far from one need more
//  passes, the extreme exponents of binary64 by far the most.
//  Zero, infinity and NaN skip the limb unit and go from decode straight to count.
//  The result register lets the next sample be taken while a beat waits; a
//  final sample adds ten report beats, one per cycle when results is not stalled.
//  Reset clears the sequencer, the result valid and all ten bins at once.
//
// The magnitude is m * 2^e with an integer significand m. When the value is
// at least one, its integer part is held in the limb RAM and divided by ten
// until it drops below ten; what is left is the digit. When the value is below
// one, m is multiplied by ten until it reaches 2^-e, and the digit is then the
// four bits at and above that position. Both loops are exact, so ties such as
// exactly 1000.0 or 0.5 land on the right digit.
// ============================================================================
module leading_digit_histogram_unit (
	input  logic clk,
	input  logic arst_n,
	ldh_sample_if.sink   samples,
	ldh_result_if.source results
);

	import ldh_pkg::*;

	localparam logic [BIN_IW-1:0] LAST_BIN = BIN_IW'(BIN_COUNT - 1);

	ldh_state_t state_q, state_d;

	// Sample and decode registers
	logic [63:0]        smp_q;
	logic               fin_q;
	logic [52:0]        src_q;
	logic [5:0]         w_q;
	logic [3:0]         b_q;
	logic [LIMB_AW-1:0] hi_q;
	logic [LIMB_AW-1:0] kw_q;
	logic [3:0]         kb_q;
	logic               int_q;

	// Pass state
	logic [LIMB_AW-1:0] idx_q;
	logic [3:0]         carry_q;
	logic               flag_q;
	logic [LIMB_AW-1:0] nhi_q;
	logic [3:0]         dig_q;

	// Bins and result register
	logic [COUNT_WIDTH-1:0] bins_q [BIN_COUNT];
	logic [BIN_IW-1:0]      rpt_q;
	logic                   out_vld_q;
	logic                   kind_q;
	logic [3:0]             odig_q;
	logic [RESULT_CNT_W-1:0] ocnt_q;
	logic                   oend_q;

	// ------------------------------------------------------------------------
	// Decode of the binary64 pattern
	// ------------------------------------------------------------------------
	logic [10:0] expf;
	logic [51:0] fracf;
	logic [52:0] mant;
	logic        is_special;
	logic        e_nonneg;
	logic [10:0] exp_pos;
	logic [10:0] kk;
	logic [52:0] ip;
	logic        dec_int;
	logic [10:0] top_pos;

	always_comb begin
		expf       = smp_q[62:52];
		fracf      = smp_q[51:0];
		mant       = {expf != 11'd0, fracf};
		is_special = (expf == EXP_ALL_ONES) || ((expf == 11'd0) && (fracf == 52'd0));
		e_nonneg   = expf >= EXP_BIAS_INT;
		exp_pos    = expf - EXP_BIAS_INT;
		kk         = (expf == 11'd0) ? SUBNORM_K : (EXP_BIAS_INT - expf);
		ip         = (kk < 11'd64) ? (mant >> kk[5:0]) : 53'd0;
		dec_int    = e_nonneg || (ip != 53'd0);
		top_pos    = {1'b0, exp_pos[9:0]} + 11'd52;
	end

	// ------------------------------------------------------------------------
	// Load of the magnitude into the limbs
	// ------------------------------------------------------------------------
	logic [7:0][LIMB_W-1:0] wide_limbs;
	logic [LIMB_AW-1:0]     rel;
	logic [LIMB_W-1:0]      load_limb;
	logic                   load_ge;

	always_comb begin
		wide_limbs = {75'd0, src_q} << b_q;
		rel        = idx_q - {1'b0, w_q};
		load_limb  = (idx_q < {1'b0, w_q}) ? '0 : wide_limbs[rel[2:0]];
		load_ge    = flag_q || ((idx_q != '0) && (load_limb != '0))
			|| ((idx_q == '0) && (load_limb >= LIMB_W'(10)));
	end

	// ------------------------------------------------------------------------
	// Shared limb unit: times ten with carry, or divide by ten with remainder
	// ------------------------------------------------------------------------
	logic [LIMB_W-1:0]  rd_data;
	logic [LIMB_W-1:0]  limb_in;
	logic [19:0]        mul_p;
	logic [19:0]        div_cur;
	logic [38:0]        div_prod;
	logic [LIMB_W-1:0]  div_q;
	logic [19:0]        div_rem;
	logic [LIMB_W-1:0]  pass_out;
	logic [3:0]         pass_carry;
	logic               pass_last;
	logic [LIMB_AW-1:0] next_idx;
	logic               hit;
	logic               crossed;
	logic               ge10;
	logic [LIMB_W-1:0]  hit_bits;
	logic [31:0]        hi_window;

	always_comb begin
		limb_in  = (!int_q && (idx_q > hi_q)) ? '0 : rd_data;
		mul_p    = {1'b0, limb_in, 3'b000} + {3'b000, limb_in, 1'b0} + {16'd0, carry_q};
		div_cur  = {carry_q, limb_in};
		div_prod = {19'd0, div_cur} * {20'd0, DIV10_RECIP};
		div_q    = div_prod[DIV10_SHIFT +: LIMB_W];
		div_rem  = div_cur - ({1'b0, div_q, 3'b000} + {3'b000, div_q, 1'b0});
		if (int_q) begin
			pass_out   = div_q;
			pass_carry = div_rem[3:0];
			pass_last  = idx_q == '0;
			next_idx   = idx_q - 1'b1;
		end else begin
			pass_out   = mul_p[LIMB_W-1:0];
			pass_carry = mul_p[19:16];
			pass_last  = idx_q == (hi_q + 1'b1);
			next_idx   = idx_q + 1'b1;
		end
		hit_bits  = pass_out >> kb_q;
		hi_window = {pass_out, 16'd0} >> kb_q;
		hit       = ((idx_q == kw_q) && (hit_bits != '0)) || ((idx_q > kw_q) && (pass_out != '0));
		crossed   = flag_q || hit;
		ge10      = flag_q || (pass_out >= LIMB_W'(10));
	end

	// ------------------------------------------------------------------------
	// Bins
	// ------------------------------------------------------------------------
	logic [BIN_IW-1:0]            bin_sel;
	logic [COUNT_WIDTH-1:0]       bin_cur;
	logic [COUNT_WIDTH-1:0]       bin_inc;
	logic [COUNT_WIDTH+31:0]      cnt_ext;
	logic [COUNT_WIDTH+31:0]      inc_ext;
	logic                         bins_zero;

	always_comb begin
		bin_sel = (state_q == ST_REPORT) ? rpt_q : dig_q;
		bin_cur = bins_q[bin_sel];
		bin_inc = (&bin_cur) ? bin_cur : bin_cur + 1'b1;
		cnt_ext = {32'd0, bin_cur};
		inc_ext = {32'd0, bin_inc};
		bins_zero = 1'b1;
		for (int i = 0; i < BIN_COUNT; i++) begin
			if (bins_q[i] != '0) begin
				bins_zero = 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------------
	logic out_free;

	assign out_free = !out_vld_q || results.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (samples.valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = is_special ? ST_COUNT : ST_LOAD;
			end
			ST_LOAD: begin
				if (idx_q == hi_q) begin
					state_d = (int_q && !load_ge) ? ST_COUNT : ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				state_d = ST_PASS;
			end
			ST_PASS: begin
				if (pass_last) begin
					if (int_q) begin
						state_d = ge10 ? ST_ISSUE : ST_COUNT;
					end else begin
						state_d = crossed ? ST_COUNT : ST_ISSUE;
					end
				end
			end
			ST_COUNT: begin
				if (out_free) begin
					state_d = fin_q ? ST_REPORT : ST_IDLE;
				end
			end
			ST_REPORT: begin
				if (out_free && (rpt_q == LAST_BIN)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------------
	// Sequencer: outputs
	// ------------------------------------------------------------------------
	logic               ram_we;
	logic [LIMB_W-1:0]  ram_wdata;
	logic [LIMB_AW-1:0] ram_raddr;
	logic               out_load;
	logic               take;

	always_comb begin
		take      = 1'b0;
		ram_we    = 1'b0;
		ram_wdata = pass_out;
		ram_raddr = next_idx;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				take = 1'b1;
			end
			ST_LOAD: begin
				ram_we    = 1'b1;
				ram_wdata = load_limb;
			end
			ST_ISSUE: begin
				ram_raddr = int_q ? hi_q : '0;
			end
			ST_PASS: begin
				ram_we = 1'b1;
			end
			ST_COUNT, ST_REPORT: begin
				out_load = out_free;
			end
			default: begin
				take = 1'b0;
			end
		endcase
	end

	assign samples.ready = take;

	ldh_ram #(
		.WIDTH(LIMB_W),
		.DEPTH(LIMB_COUNT)
	) u_limbs (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	// ------------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
			rpt_q     <= '0;
			for (int i = 0; i < BIN_COUNT; i++) begin
				bins_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
			if (out_load && (state_q == ST_COUNT)) begin
				bins_q[dig_q] <= bin_inc;
			end
			if (out_load && (state_q == ST_REPORT)) begin
				bins_q[rpt_q] <= '0;
				rpt_q         <= (rpt_q == LAST_BIN) ? '0 : rpt_q + 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (samples.valid) begin
					smp_q <= samples.sample_bits;
					fin_q <= samples.final_sample;
				end
			end
			ST_DECODE: begin
				// Values of one and above keep their integer part; smaller ones
				// keep m and scale it up towards 2^k.
				src_q  <= e_nonneg ? mant : (dec_int ? ip : mant);
				w_q    <= e_nonneg ? exp_pos[9:4] : '0;
				b_q    <= e_nonneg ? exp_pos[3:0] : '0;
				hi_q   <= e_nonneg ? {1'b0, top_pos[9:4]} : LIMB_AW'(3);
				kw_q   <= kk[10:4];
				kb_q   <= kk[3:0];
				int_q  <= dec_int;
				dig_q  <= '0;
				idx_q  <= '0;
				flag_q <= 1'b0;
			end
			ST_LOAD: begin
				idx_q <= idx_q + 1'b1;
				if (int_q) begin
					flag_q <= load_ge;
					if (idx_q == '0) begin
						dig_q <= load_limb[3:0];
					end
				end
			end
			ST_ISSUE: begin
				idx_q   <= int_q ? hi_q : '0;
				carry_q <= '0;
				flag_q  <= 1'b0;
				nhi_q   <= '0;
			end
			ST_PASS: begin
				idx_q   <= next_idx;
				carry_q <= pass_carry;
				if (int_q) begin
					// Track the new top limb while walking down.
					if (!flag_q && (pass_out != '0) && (idx_q != '0)) begin
						flag_q <= 1'b1;
						nhi_q  <= idx_q;
					end
					if (pass_last) begin
						if (ge10) begin
							hi_q <= flag_q ? nhi_q : '0;
						end else begin
							dig_q <= pass_out[3:0];
						end
					end
				end else begin
					flag_q <= crossed;
					if (idx_q == kw_q) begin
						dig_q <= hit_bits[3:0];
					end else if (idx_q == (kw_q + 1'b1)) begin
						dig_q <= dig_q | hi_window[3:0];
					end
					if (pass_last && (pass_out != '0)) begin
						hi_q <= hi_q + 1'b1;
					end
				end
			end
			ST_COUNT: begin
				if (out_load) begin
					kind_q <= KIND_DIGIT;
					odig_q <= dig_q;
					ocnt_q <= inc_ext[RESULT_CNT_W-1:0];
					oend_q <= !fin_q;
				end
			end
			ST_REPORT: begin
				if (out_load) begin
					kind_q <= KIND_REPORT;
					odig_q <= rpt_q;
					ocnt_q <= cnt_ext[RESULT_CNT_W-1:0];
					oend_q <= rpt_q == LAST_BIN;
				end
			end
			default: begin
				flag_q <= flag_q;
			end
		endcase
	end

	assign results.valid     = out_vld_q;
	assign results.kind      = kind_q;
	assign results.digit     = odig_q;
	assign results.bin_count = ocnt_q;
	assign results.run_end   = oend_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COUNT) |-> (dig_q <= 4'd9))
		else $error("digit out of range when counting");

	a_limb_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (idx_q < LIMB_AW'(LIMB_COUNT)))
		else $error("limb write beyond the limb store");

	a_bins_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_REPORT) && out_load && (rpt_q == LAST_BIN)) |=> bins_zero)
		else $error("bins not all clear after a report");

endmodule

// ===== tb/sv/ldh_histogram_checker.sv =====
// ============================================================================
// Leading digit histogram checker
// Watches the sample and result channels, predicts every result beat with an
// exact wide-integer leading digit calculation and its own ten bins, and
// compares each result beat field by field with the oldest prediction.
// ============================================================================
module ldh_histogram_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	ldh_sample_if                        samples,
	ldh_result_if                        results,
	output int                           fail_count,
	output int                           pending_beats,
	output int                           beats_checked,
	output bit [ldh_pkg::BIN_COUNT-1:0]  digits_seen
);

	import ldh_pkg::*;

	localparam int   PRINT_CAP   = 40;

	// Wide enough for the largest binary64 integer part (below 2^1024) and for
	// the smallest subnormal significand scaled up to 2^1074 by tens.
	typedef logic [1151:0] magnitude_t;

	typedef struct packed {
		logic                    kind;
		logic [BIN_IW-1:0]       digit;
		logic [RESULT_CNT_W-1:0] bin_count;
		logic                    run_end;
	} result_beat_t;

	result_beat_t           expected_beats[$];
	bit [COUNT_WIDTH-1:0]   bin_tally [BIN_COUNT];
	logic [BIN_IW-1:0]      lead;
	result_beat_t           want;

	// Exact leading decimal digit of |value|; zero, infinity and NaN give 0.
	function automatic logic [BIN_IW-1:0] decimal_lead_digit(input logic [63:0] bits);
		logic [10:0] expf;
		logic [51:0] frac;
		logic [52:0] signif;
		int          pow2;
		int          shift_up;
		int          shift_down;
		magnitude_t  mag;
		magnitude_t  whole;
		expf = bits[62:52];
		frac = bits[51:0];
		if (expf == EXP_ALL_ONES || (expf == '0 && frac == '0))
			return '0;
		if (expf == '0) begin
			signif = {1'b0, frac};
			pow2   = -int'(SUBNORM_K);
		end else begin
			signif = {1'b1, frac};
			pow2   = int'(expf) - int'(EXP_BIAS_INT);
		end
		shift_up   = (pow2 >= 0) ? pow2 : 0;
		shift_down = (pow2 < 0) ? -pow2 : 0;
		mag   = magnitude_t'(signif) << shift_up;
		whole = mag >> shift_down;
		if (whole != '0) begin
			while (whole >= 10)
				whole = whole / 10;
			return whole[BIN_IW-1:0];
		end
		// Below one: scale by ten until the integer part becomes non-zero.
		while ((mag >> shift_down) == '0)
			mag = mag * 10;
		whole = mag >> shift_down;
		return whole[BIN_IW-1:0];
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned wanted,
		input longint unsigned got);
		if (fail_count < PRINT_CAP)
			$display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, wanted, got);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_beats.delete();
			for (int i = 0; i < BIN_COUNT; i++)
				bin_tally[i] = '0;
			pending_beats = 0;
		end else begin
			if (samples.valid && samples.ready) begin
				lead = decimal_lead_digit(samples.sample_bits);
				digits_seen[lead] = 1'b1;
				if (bin_tally[lead] != '1)
					bin_tally[lead] = bin_tally[lead] + 1'b1;
				expected_beats.push_back('{KIND_DIGIT, lead,
					RESULT_CNT_W'(bin_tally[lead]), !samples.final_sample});
				if (samples.final_sample) begin
					for (int i = 0; i < BIN_COUNT; i++)
						expected_beats.push_back('{KIND_REPORT, BIN_IW'(i),
							RESULT_CNT_W'(bin_tally[i]), i == BIN_COUNT - 1});
					for (int i = 0; i < BIN_COUNT; i++)
						bin_tally[i] = '0;
				end
			end
			if (results.valid && results.ready) begin
				beats_checked++;
				if (expected_beats.size() == 0) begin
					report_mismatch("result beat with nothing outstanding, digit", 0,
						results.digit);
				end else begin
					want = expected_beats.pop_front();
					if (results.kind !== want.kind)
						report_mismatch("kind", want.kind, results.kind);
					if (results.digit !== want.digit)
						report_mismatch("digit", want.digit, results.digit);
					if (results.bin_count !== want.bin_count)
						report_mismatch("bin_count", want.bin_count, results.bin_count);
					if (results.run_end !== want.run_end)
						report_mismatch("run_end", want.run_end, results.run_end);
				end
			end
			pending_beats = expected_beats.size();
		end
	end

endmodule

// ===== tb/sv/tb_leading_digit_histogram_unit.sv =====
// ============================================================================
// Leading digit histogram unit testbench
// Drives binary64 samples into the unit, directed corner values first and then
// random data sets, with random gaps on the sample side and random stalls on
// the result side. A checker beside the unit predicts and compares every beat;
// this module makes the stimulus, watches the cycle limit and gives the verdict.
// ============================================================================
module tb_leading_digit_histogram_unit;

	import ldh_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 3;
	localparam int RANDOM_ITEMS = 136;
	localparam int MAX_IDLE     = 10;
	localparam int DRAIN_CYCLES = 50;

	// The slowest samples (the smallest subnormals and the largest finite
	// values) cost the unit the most time. Even if all 160 samples were that
	// slow, with the longest gaps before each sample and the longest stalls on
	// each of up to eleven result beats, the limit would leave a wide margin.
	localparam int CYCLE_LIMIT  = 10_000_000;

	logic clk = 1'b0;
	logic arst_n;

	int              fail_count;
	int              pending_beats;
	int              beats_checked;
	bit [BIN_COUNT-1:0] digits_seen;

	int cycle_count;
	int samples_sent;
	int directed_sent;
	int sets_reported;
	int set_len;
	int stall_left;
	bit sender_burst;
	bit receiver_burst;

	ldh_sample_if sample_ch();
	ldh_result_if result_ch();

	leading_digit_histogram_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.results (result_ch)
	);

	ldh_histogram_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.samples       (sample_ch),
		.results       (result_ch),
		.fail_count    (fail_count),
		.pending_beats (pending_beats),
		.beats_checked (beats_checked),
		.digits_seen   (digits_seen)
	);

	always #CLK_HALF clk = ~clk;

	// Watchdog: a hung handshake or a runaway scaling loop ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d result beats outstanding",
				cycle_count, pending_beats);
			$display("Verification failed");
			$finish;
		end
	end

	// Random binary64 pattern. Most exponents sit close to unity, where the unit
	// is quick; a smaller share spreads over a few hundred binades, and only a
	// few span the whole range, since those are the slowest for the unit.
	// The sign bit is always random and the fraction bits mostly so; now and then the low
	// fraction bits are cleared so that exact values such as 1000.0 turn up.
	function automatic logic [63:0] random_sample_bits();
		logic        sign;
		logic [10:0] expf;
		logic [51:0] frac;
		int          pick;
		sign = 1'($urandom_range(0, 1));
		frac = 52'({$urandom(), $urandom()});
		pick = $urandom_range(0, 99);
		if (pick < 78) begin
			expf = 11'(1003 + $urandom_range(0, 40));
		end else if (pick < 90) begin
			expf = 11'(823 + $urandom_range(0, 400));
		end else if (pick < 96) begin
			expf = 11'($urandom_range(0, 2047));
		end else begin
			case ($urandom_range(0, 3))
				0: expf = '0;
				1: expf = EXP_ALL_ONES;
				2: begin
					expf = '0;
					frac = '0;
				end
				default: begin
					expf = 11'd1023;
					frac = '0;
				end
			endcase
		end
		if ($urandom_range(0, 9) == 0)
			frac[40:0] = '0;
		return {sign, expf, frac};
	endfunction

	// Offers one sample beat. The task is entered and left at a falling edge;
	// valid is only dropped when a gap is drawn, so back-to-back beats keep it
	// high with a single assignment per time step.
	task automatic send_sample(input logic [63:0] bits, input logic last);
		int gap;
		if ($urandom_range(0, 11) == 0)
			sender_burst = !sender_burst;
		gap = sender_burst ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			sample_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid        = 1'b1;
		sample_ch.sample_bits  = bits;
		sample_ch.final_sample = last;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		samples_sent++;
		if (last)
			sets_reported++;
		@(negedge clk);
	endtask

	// Result side: after each accepted beat a random stall is drawn,
	// and ready changes only at falling edges. Stretches with no stalls at all
	// come from the burst mode, which flips now and then.
	initial begin
		result_ch.ready = 1'b0;
		stall_left      = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				if ($urandom_range(0, 19) == 0)
					receiver_burst = !receiver_burst;
				stall_left = receiver_burst ? 0 : $urandom_range(0, MAX_IDLE);
			end
			@(negedge clk);
			if (stall_left > 0) begin
				result_ch.ready = 1'b0;
				stall_left--;
			end else begin
				result_ch.ready = arst_n;
			end
		end
	end

	initial begin
		arst_n                 = 1'b0;
		sample_ch.valid        = 1'b0;
		sample_ch.sample_bits  = '0;
		sample_ch.final_sample = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. Zero, infinity and NaN in both signs all land in bin 0;
		// the first report closes that set so bin 0 alone carries a count.
		send_sample(64'h0000_0000_0000_0000, 1'b0);	// positive zero
		send_sample(64'h8000_0000_0000_0000, 1'b0);	// negative zero
		send_sample(64'h7FF0_0000_0000_0000, 1'b0);	// positive infinity
		send_sample(64'hFFF0_0000_0000_0000, 1'b0);	// negative infinity
		send_sample(64'h7FF8_0000_0000_0000, 1'b0);	// quiet NaN
		send_sample(64'h7FF0_0000_0000_0001, 1'b0);	// signalling NaN with payload
		send_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);	// all bits set, a NaN
		// Extremes of the range: subnormals and the largest finite values.
		send_sample(64'h0000_0000_0000_0001, 1'b0);	// smallest subnormal, 4.9e-324
		send_sample(64'h000F_FFFF_FFFF_FFFF, 1'b0);	// largest subnormal
		send_sample(64'h0010_0000_0000_0000, 1'b0);	// smallest normal
		send_sample(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);	// largest finite
		send_sample(64'hFFEF_FFFF_FFFF_FFFF, 1'b0);	// its negative
		// Exact powers of ten and of two, where an inexact scaling would slip.
		send_sample(64'h3FF0_0000_0000_0000, 1'b0);	// 1.0
		send_sample(64'h3FE0_0000_0000_0000, 1'b0);	// 0.5
		send_sample(64'h408F_4000_0000_0000, 1'b0);	// 1000.0
		send_sample(64'h3FB9_9999_9999_999A, 1'b0);	// 0.1, just above one tenth
		send_sample(64'h4022_0000_0000_0000, 1'b0);	// 9.0
		send_sample(64'h4024_0000_0000_0000, 1'b0);	// 10.0
		send_sample(64'hC01E_0000_0000_0000, 1'b0);	// -7.5
		send_sample(64'h43F0_0000_0000_0000, 1'b0);	// 2^64, past a 64-bit cast
		send_sample(64'h3FD3_3333_3333_3333, 1'b0);	// 0.3, just below
		send_sample(64'h4018_0000_0000_0000, 1'b0);	// 6.0
		send_sample(64'h4020_0000_0000_0000, 1'b0);	// 8.0
		send_sample(64'h800A_AAAA_AAAA_AAAA, 1'b1);	// negative subnormal, report
		directed_sent = samples_sent;

		// Random part: whole data sets, each closed by a final sample, mostly of
		// moderate length with the odd single-sample set. The last set is cut
		// short so the run ends on the planned sample count.
		while (samples_sent - directed_sent < RANDOM_ITEMS) begin
			set_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
			if (set_len > RANDOM_ITEMS - (samples_sent - directed_sent))
				set_len = RANDOM_ITEMS - (samples_sent - directed_sent);
			for (int j = 0; j < set_len; j++)
				send_sample(random_sample_bits(), j == set_len - 1);
		end
		sample_ch.valid = 1'b0;

		while (pending_beats != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Run covered %0d samples (%0d directed) in %0d reported data sets.",
			samples_sent, directed_sent, sets_reported);
		$display("Result beats checked: %0d; leading digits seen, 9 down to 0: %b",
			beats_checked, digits_seen);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
